@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define TLI_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition is followed in the next cycle by a consequence.
`define TLI_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/tli_pkg.sv @@
package tli_pkg;

	// Function codes carried in the request sideband.
	localparam logic [1:0] FN_LOAD = 2'd0;
	localparam logic [1:0] FN_FWD  = 2'd1;
	localparam logic [1:0] FN_INV  = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_INTERP = 2'd0;
	localparam logic [1:0] ST_LOW    = 2'd1;
	localparam logic [1:0] ST_HIGH   = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	// Result source select.
	localparam logic [1:0] RS_ZERO = 2'd0;
	localparam logic [1:0] RS_CUR  = 2'd1;
	localparam logic [1:0] RS_QUOT = 2'd2;

	localparam logic [16:0] PROB_ONE = 17'd65536;

	// The quotient always fits in 32 bits, one bit per divider step.
	localparam int DIV_STEPS = 32;
	// Four partial products; a final accumulate step adds the last of them.
	localparam int MUL_STEPS = 4;

	typedef struct packed {
		logic       wr_en;
		logic       q_load;
		logic       prev_load;
		logic       interp_load;
		logic       mul_go;
		logic       acc_go;
		logic [1:0] mul_sel;
		logic       div_init;
		logic       div_step;
		logic       res_load;
		logic [1:0] res_sel;
		logic [1:0] res_status;
		logic       out_load;
	} tli_cmd_t;

	typedef struct packed {
		logic key_gt_q;
		logic out_busy;
	} tli_stat_t;

endpackage

@@ rtl/tli_dpath.sv @@
`include "assert_macros.svh"

module tli_dpath #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tli_pkg::tli_cmd_t             cmd,
	input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
	input  logic [1:0]                    func,
	input  logic [7:0]                    entry_index,
	input  logic signed [31:0]            entry_abscissa,
	input  logic [16:0]                   entry_probability,
	input  logic signed [31:0]            query_value,
	output tli_pkg::tli_stat_t            stat,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,
	output logic [1:0]                    m_tuser
);
	import tli_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [31:0] abs_mem [TABLE_DEPTH];
	logic [16:0] prob_mem [TABLE_DEPTH];

	logic               wr_ok;
	logic [16:0]        prob_sat;
	logic [31:0]        rd_abs_q;
	logic [16:0]        rd_prob_q;
	logic signed [31:0] q_q;
	logic               inv_q;
	logic signed [31:0] cur_key;
	logic signed [31:0] cur_val;
	logic signed [31:0] prev_key_q;
	logic signed [31:0] prev_val_q;
	logic signed [32:0] w0_d;
	logic signed [32:0] w1_d;
	logic signed [32:0] den_d;
	logic [32:0]        w0_q;
	logic [32:0]        w1_q;
	logic [32:0]        den_q;
	logic signed [31:0] v0_q;
	logic signed [31:0] v1_q;
	logic [32:0]        op_w;
	logic signed [31:0] op_v;
	logic signed [16:0] op_part;
	logic signed [50:0] prod;
	logic signed [50:0] prod_q;
	logic               prod_hi_q;
	logic signed [65:0] addend;
	logic signed [65:0] acc_q;
	logic [65:0]        mag;
	logic               neg_q;
	logic [33:0]        rem_q;
	logic [31:0]        lo_q;
	logic [31:0]        quo_q;
	logic [33:0]        trial;
	logic               fits;
	logic signed [31:0] res_q;
	logic [1:0]         res_st_q;
	logic               out_valid_q;
	logic [31:0]        out_data_q;
	logic [1:0]         out_st_q;

	assign wr_ok    = 32'(entry_index) < 32'(TABLE_DEPTH);
	assign prob_sat = (entry_probability > PROB_ONE) ? PROB_ONE : entry_probability;

	// Table storage with one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_ok) begin
			abs_mem[AW'(entry_index)]  <= entry_abscissa;
			prob_mem[AW'(entry_index)] <= prob_sat;
		end
		rd_abs_q  <= abs_mem[rd_addr];
		rd_prob_q <= prob_mem[rd_addr];
	end

	// Forward queries search abscissas, inverse queries search probabilities.
	assign cur_key = inv_q ? signed'({15'd0, rd_prob_q}) : signed'(rd_abs_q);
	assign cur_val = inv_q ? signed'(rd_abs_q) : signed'({15'd0, rd_prob_q});

	assign w0_d  = {cur_key[31], cur_key} - {q_q[31], q_q};
	assign w1_d  = {q_q[31], q_q} - {prev_key_q[31], prev_key_q};
	assign den_d = {cur_key[31], cur_key} - {prev_key_q[31], prev_key_q};

	// Each weight times a value is split into a low and a high half of the value.
	assign op_w    = cmd.mul_sel[1] ? w1_q : w0_q;
	assign op_v    = cmd.mul_sel[1] ? v1_q : v0_q;
	assign op_part = cmd.mul_sel[0] ? signed'({op_v[31], op_v[31:16]})
	                                : signed'({1'b0, op_v[15:0]});
	assign prod    = signed'({1'b0, op_w}) * op_part;
	assign addend  = prod_hi_q ? (66'(prod_q) <<< 16) : 66'(prod_q);

	assign mag   = acc_q[65] ? 66'(-acc_q) : 66'(acc_q);
	assign trial = {rem_q[32:0], lo_q[31]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.q_load) begin
			q_q   <= query_value;
			inv_q <= (func == FN_INV);
		end
		if (cmd.prev_load) begin
			prev_key_q <= cur_key;
			prev_val_q <= cur_val;
		end
		if (cmd.interp_load) begin
			w0_q  <= 33'(w0_d);
			w1_q  <= 33'(w1_d);
			den_q <= 33'(den_d);
			v0_q  <= prev_val_q;
			v1_q  <= cur_val;
			acc_q <= '0;
		end else if (cmd.acc_go) begin
			acc_q <= acc_q + addend;
		end
		if (cmd.mul_go) begin
			prod_q    <= prod;
			prod_hi_q <= cmd.mul_sel[0];
		end
		if (cmd.div_init) begin
			neg_q <= acc_q[65];
			rem_q <= mag[65:32];
			lo_q  <= mag[31:0];
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			quo_q <= {quo_q[30:0], fits};
			lo_q  <= {lo_q[30:0], 1'b0};
		end
		if (cmd.res_load) begin
			res_st_q <= cmd.res_status;
			case (cmd.res_sel)
				RS_ZERO: res_q <= '0;
				RS_CUR:  res_q <= cur_val;
				RS_QUOT: res_q <= neg_q ? signed'(-quo_q) : signed'(quo_q);
				default: res_q <= '0;
			endcase
		end
		if (cmd.out_load) begin
			out_data_q <= res_q;
			out_st_q   <= res_st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.key_gt_q = cur_key > q_q;
	assign stat.out_busy = out_valid_q;
	assign m_tvalid      = out_valid_q;
	assign m_tdata       = out_data_q;
	assign m_tuser       = out_st_q;

	`TLI_ASSERT_NEXT(a_out_load_valid, clk, arst_n, cmd.out_load, m_tvalid,
		"result register not valid after a load")
	`TLI_ASSERT(a_no_load_when_busy, clk, arst_n, !(cmd.out_load && out_valid_q && !m_tready),
		"result overwritten before it was taken")

endmodule

@@ rtl/tli_ctrl.sv @@
`include "assert_macros.svh"

module tli_ctrl #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [1:0]                     func,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [8:0]                     cfg_data,
	input  tli_pkg::tli_stat_t             stat,
	output tli_pkg::tli_cmd_t              cmd,
	output logic [$clog2(TABLE_DEPTH)-1:0] rd_addr
);
	import tli_pkg::*;

	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int NW0 = $clog2(TABLE_DEPTH + 1);
	localparam int NW  = (NW0 > 9) ? NW0 : 9;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FIRST = 3'd1;
	localparam logic [2:0] S_WALK  = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_DINIT = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_QSET  = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	logic [2:0]    state_q;
	logic [2:0]    state_d;
	logic [8:0]    cfg_q;
	logic [NW-1:0] n_eff;
	logic [NW-1:0] idx_q;
	logic [NW-1:0] idx_d;
	logic [NW-1:0] idx_nxt;
	logic [4:0]    cnt_q;
	logic [4:0]    cnt_d;
	logic          accept;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign n_eff     = (NW'(cfg_q) > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(cfg_q);
	assign idx_nxt   = idx_q + NW'(1);

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (func == FN_LOAD) begin
						cmd.wr_en = 1'b1;
					end else if (func == FN_FWD || func == FN_INV) begin
						cmd.q_load = 1'b1;
						if (n_eff == '0) begin
							cmd.res_load   = 1'b1;
							cmd.res_sel    = RS_ZERO;
							cmd.res_status = ST_EMPTY;
							state_d        = S_FIN;
						end else begin
							idx_d   = '0;
							state_d = S_FIRST;
						end
					end
				end
			end
			S_FIRST: begin
				rd_addr = AW'(1);
				if (stat.key_gt_q) begin
					cmd.res_load   = 1'b1;
					cmd.res_sel    = RS_CUR;
					cmd.res_status = ST_LOW;
					state_d        = S_FIN;
				end else if (n_eff == NW'(1)) begin
					cmd.res_load   = 1'b1;
					cmd.res_sel    = RS_CUR;
					cmd.res_status = ST_HIGH;
					state_d        = S_FIN;
				end else begin
					cmd.prev_load = 1'b1;
					idx_d         = NW'(1);
					state_d       = S_WALK;
				end
			end
			S_WALK: begin
				rd_addr = idx_nxt[AW-1:0];
				if (stat.key_gt_q) begin
					cmd.interp_load = 1'b1;
					cnt_d           = '0;
					state_d         = S_MUL;
				end else if (idx_nxt == n_eff) begin
					cmd.res_load   = 1'b1;
					cmd.res_sel    = RS_CUR;
					cmd.res_status = ST_HIGH;
					state_d        = S_FIN;
				end else begin
					cmd.prev_load = 1'b1;
					idx_d         = idx_nxt;
				end
			end
			S_MUL: begin
				cmd.mul_sel = cnt_q[1:0];
				cmd.mul_go  = (cnt_q < 5'(MUL_STEPS));
				cmd.acc_go  = (cnt_q != '0);
				cnt_d       = cnt_q + 5'd1;
				if (cnt_q == 5'(MUL_STEPS)) begin
					state_d = S_DINIT;
				end
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					state_d = S_QSET;
				end
			end
			S_QSET: begin
				cmd.res_load   = 1'b1;
				cmd.res_sel    = RS_QUOT;
				cmd.res_status = ST_INTERP;
				state_d        = S_FIN;
			end
			S_FIN: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cfg_q   <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
			if (cfg_valid && cfg_ready) begin
				cfg_q <= cfg_data;
			end
		end
	end

	`TLI_ASSERT_NEXT(a_res_then_fin, clk, arst_n, cmd.res_load, state_q == S_FIN,
		"result latched without moving to the output step")
	`TLI_ASSERT_NEXT(a_div_len, clk, arst_n,
		(state_q == S_DIV) && (cnt_q == 5'(DIV_STEPS - 1)), state_q == S_QSET,
		"divider did not finish after its last step")
	`TLI_ASSERT_NEXT(a_fin_drain, clk, arst_n, (state_q == S_FIN) && !stat.out_busy,
		state_q == S_IDLE, "finished result not handed to the output register")
	`TLI_ASSERT(a_walk_bound, clk, arst_n, !(state_q == S_WALK) || (idx_q < n_eff),
		"table walk went past the entries in use")

endmodule

@@ rtl/table_linear_interpolator_unit.sv @@
// Piecewise linear interpolation over a loaded table of ascending abscissa
// points (signed Q16.16) and their cumulative probabilities (Q1.16). A load
// request (tuser 0) writes one entry and gives no result; a load
// whose index is at or beyond TABLE_DEPTH is dropped and a probability above
// one is saturated. A forward request (tuser 1) maps an abscissa to a
// probability and an inverse request (tuser 2) maps a probability to an
// abscissa; each returns one result whose tuser holds the status: interpolated,
// clamped low, clamped high or table empty. The cfg channel sets how many
// entries, from index 0, queries search; it must only be written while the
// block is idle, and every entry a query can reach must have been loaded first.
// One request is handled at a time. A query walks the table one entry per cycle
// through the single read port of the table memory, and an interpolated query
// then runs the partial-product multiplication and the bit-serial divider. A
// finished result waits in the output register, and loads are still accepted
// while it waits.
module table_linear_interpolator_unit #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request channel.
	input  logic        s_tvalid,
	output logic        s_tready,
	// entry_index[7:0], entry_abscissa[39:8], entry_probability[56:40],
	// query_value[88:57], zero padding[95:89]
	input  logic [95:0] s_tdata,
	// func[1:0]
	input  logic [1:0]  s_tuser,
	// Result channel.
	output logic        m_tvalid,
	input  logic        m_tready,
	// result_value[31:0]
	output logic [31:0] m_tdata,
	// status[1:0]
	output logic [1:0]  m_tuser,
	// Register write for entries_in_use.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data
);
	import tli_pkg::*;

	tli_cmd_t                       cmd;
	tli_stat_t                      stat;
	logic [$clog2(TABLE_DEPTH)-1:0] rd_addr;

	// The controller sequences the walk, multiply and divide steps.
	tli_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.func     (s_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.stat     (stat),
		.cmd      (cmd),
		.rd_addr  (rd_addr)
	);

	// The datapath holds the tables, the arithmetic and the result register.
	tli_dpath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.rd_addr          (rd_addr),
		.func             (s_tuser),
		.entry_index      (s_tdata[7:0]),
		.entry_abscissa   (s_tdata[39:8]),
		.entry_probability(s_tdata[56:40]),
		.query_value      (s_tdata[88:57]),
		.stat             (stat),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.m_tuser          (m_tuser)
	);

endmodule

@@ verif/table_linear_interpolator_unit_tb.sv @@
`timescale 1ns / 1ps

module table_linear_interpolator_unit_tb;
	import tli_pkg::*;

	// The one function code that the block ignores entirely.
	localparam logic [1:0] FN_NONE = 2'd3;
	localparam int DEPTH = 256;
	localparam int TARGET_REQUESTS = 1550;
	// Worst case is far below this: each request takes at most a full table walk,
	// the multiplier and the divider, plus random stalls on both sides.
	localparam longint CYCLE_LIMIT = 3000000;
	// A query stops after at most a full walk, the multiplier and the divider.
	localparam int DRAIN_CYCLES = 400;
	localparam int LONG_HOLD_CYCLES = 600;

	typedef struct {
		logic [1:0]         func;
		logic [7:0]         idx;
		logic signed [31:0] abscissa;
		logic [16:0]        prob;
		logic signed [31:0] query;
	} request_t;

	typedef struct {
		logic [31:0] value;
		logic [1:0]  status;
	} lookup_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [8:0]  cfg_data;

	// Requests waiting for the driver, and the results the block still owes.
	request_t       request_queue[$];
	lookup_result_t owed_results[$];

	// Predictor state: the table and the entry count as the block should see them.
	logic signed [31:0] model_abscissa[DEPTH];
	logic [16:0]        model_prob[DEPTH];
	logic [8:0]         model_entries;

	// Shadow of the table on the generator side, used to aim query values.
	longint gen_abscissa[DEPTH];
	longint gen_prob[DEPTH];

	bit         no_idle;
	bit         cfg_pending;
	logic [8:0] cfg_next;
	int         hold_requests;
	int         hold_served;
	int         hold_left;
	int         send_gap;
	int         recv_gap;
	int         mismatches;
	int         results_seen;
	int         queries_sent;
	int         loads_sent;
	int         requests_made;
	int         phases_run;
	longint     cycles;

	table_linear_interpolator_unit #(
		.TABLE_DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 6);
	endfunction

	// Key and value of entry i in the role the query gives them: a forward
	// query searches abscissas and returns probabilities, an inverse one the
	// other way around.
	function automatic longint key_at(input bit inverse, input int i);
		return inverse ? longint'(model_prob[i]) : longint'(model_abscissa[i]);
	endfunction

	function automatic longint value_at(input bit inverse, input int i);
		return inverse ? longint'(model_abscissa[i]) : longint'(model_prob[i]);
	endfunction

	// Expected result of one query against the current predictor table.
	function automatic lookup_result_t interpolate(input bit inverse, input longint q);
		lookup_result_t r;
		int     n;
		longint w0;
		longint w1;
		longint den;
		longint num;
		n = (model_entries > DEPTH) ? DEPTH : int'(model_entries);
		if (n == 0) begin
			r.value = '0;
			r.status = ST_EMPTY;
			return r;
		end
		if (q < key_at(inverse, 0)) begin
			r.value = 32'(value_at(inverse, 0));
			r.status = ST_LOW;
			return r;
		end
		// The first key above the query decides the segment, sorted or not.
		for (int i = 1; i < n; i++) begin
			if (key_at(inverse, i) > q) begin
				w0 = key_at(inverse, i) - q;
				w1 = q - key_at(inverse, i - 1);
				den = key_at(inverse, i) - key_at(inverse, i - 1);
				num = w0 * value_at(inverse, i - 1) + w1 * value_at(inverse, i);
				r.value = 32'(num / den);
				r.status = ST_INTERP;
				return r;
			end
		end
		r.value = 32'(value_at(inverse, n - 1));
		r.status = ST_HIGH;
		return r;
	endfunction

	// Driver: presents queued requests, with a random pause after each one.
	always @(posedge clk or negedge arst_n) begin
		logic [1:0]  func;
		logic [16:0] prob;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				func = s_tuser;
				if (func == FN_LOAD) begin
					// Probabilities above one are stored as exactly one.
					prob = (s_tdata[56:40] > PROB_ONE) ? PROB_ONE : s_tdata[56:40];
					model_abscissa[s_tdata[7:0]] = s_tdata[39:8];
					model_prob[s_tdata[7:0]] = prob;
				end else if (func == FN_FWD || func == FN_INV) begin
					owed_results.push_back(interpolate(func == FN_INV,
						longint'($signed(s_tdata[88:57]))));
				end
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (request_queue.size() > 0) begin
					request_t r;
					r = request_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= r.func;
					s_tdata <= {7'd0, r.query, r.prob, r.abscissa, r.idx};
					send_gap <= draw_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, started on demand from the stimulus process.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_served <= 0;
			hold_left <= 0;
		end else if (hold_requests != hold_served) begin
			hold_served <= hold_requests;
			hold_left <= LONG_HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: takes results with random stalls and checks them in order.
	always @(posedge clk or negedge arst_n) begin
		lookup_result_t want;
		int r;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (owed_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result: value %h status %0d", m_tdata, m_tuser);
				end else begin
					want = owed_results.pop_front();
					if (m_tdata !== want.value || m_tuser !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected %h/%0d, got %h/%0d",
								want.value, want.status, m_tdata, m_tuser);
					end
				end
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
			end else if (m_tvalid && m_tready) begin
				r = draw_gap();
				m_tready <= (r == 0);
				recv_gap <= (r == 0) ? 0 : r - 1;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Register writes, requested by the stimulus process while the block is idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_data <= '0;
			model_entries <= '0;
		end else if (cfg_valid && cfg_ready) begin
			model_entries <= cfg_data;
			cfg_valid <= 1'b0;
		end else if (!cfg_valid && cfg_pending) begin
			cfg_valid <= 1'b1;
			cfg_data <= cfg_next;
			cfg_pending = 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout with %0d results still owed", owed_results.size());
			$display("table_linear_interpolator_unit_tb NOT OK");
			$finish;
		end
	end

	task automatic push_request(input logic [1:0] func, input logic [7:0] idx,
			input longint abscissa, input longint prob, input longint query);
		request_t r;
		r.func = func;
		r.idx = idx;
		r.abscissa = abscissa[31:0];
		r.prob = prob[16:0];
		r.query = query[31:0];
		request_queue.push_back(r);
		if (func == FN_LOAD) begin
			gen_abscissa[idx] = longint'($signed(abscissa[31:0]));
			gen_prob[idx] = longint'((prob[16:0] > PROB_ONE) ? PROB_ONE : prob[16:0]);
			loads_sent++;
		end else if (func != FN_NONE) begin
			queries_sent++;
		end
		if (func != FN_NONE)
			requests_made++;
	endtask

	// Waits until every request is sent and every result is back, then lets the
	// block settle after any trailing load.
	task automatic wait_idle();
		do @(negedge clk);
		while (request_queue.size() > 0 || s_tvalid || owed_results.size() > 0);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_entries(input int value);
		@(negedge clk);
		cfg_next = value[8:0];
		cfg_pending = 1'b1;
		do @(negedge clk);
		while (cfg_pending || cfg_valid);
	endtask

	// Picks a query value that lands near the table most of the time.
	function automatic longint pick_query(input bit inverse, input int n);
		int     k;
		longint a;
		longint b;
		k = (n > 0) ? $urandom_range(0, n - 1) : 0;
		a = inverse ? gen_prob[k] : gen_abscissa[k];
		b = (k + 1 < n) ? (inverse ? gen_prob[k + 1] : gen_abscissa[k + 1]) : a + 1000;
		case ($urandom_range(0, 5))
			0: return a;
			1: return a + ((b - a) * $urandom_range(0, 1000)) / 1000;
			2: return a - $urandom_range(1, 70000);
			3: return a + $urandom_range(1, 70000);
			4: return inverse ? longint'($urandom_range(0, 65536)) : a + 1;
			default: return longint'($signed($urandom()));
		endcase
	endfunction

	initial begin
		int     n;
		int     shape;
		int     count;
		longint a;
		longint p;
		cfg_pending = 1'b0;
		cfg_next = '0;
		hold_requests = 0;
		no_idle = 1'b0;
		mismatches = 0;
		results_seen = 0;
		queries_sent = 0;
		loads_sent = 0;
		requests_made = 0;
		phases_run = 0;
		cycles = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty table, both query kinds, and the ignored function code.
		push_request(FN_FWD, 0, 0, 0, 0);
		push_request(FN_INV, 0, 0, 0, -1);
		push_request(FN_NONE, 8'hFF, -1, 17'h1FFFF, -1);
		// Extreme abscissas; the last probability saturates to one.
		push_request(FN_LOAD, 0, 64'hFFFFFFFF80000000, 0, 0);
		push_request(FN_LOAD, 1, 32'hFFFF0000, 1, 0);
		push_request(FN_LOAD, 2, 32'h00010000, 40000, 0);
		push_request(FN_LOAD, 3, 32'h7FFFFFFF, 17'h1FFFF, 0);
		wait_idle();
		write_entries(4);
		push_request(FN_FWD, 0, 0, 0, 64'hFFFFFFFF80000000);
		push_request(FN_FWD, 0, 0, 0, 0);
		push_request(FN_FWD, 0, 0, 0, 32'h7FFFFFFF);
		push_request(FN_INV, 0, 0, 0, -5);
		push_request(FN_INV, 0, 0, 0, 20000);
		push_request(FN_INV, 0, 0, 0, 65536);
		push_request(FN_INV, 0, 0, 0, 32'h7FFFFFFF);
		wait_idle();
		// A single entry can only clamp.
		write_entries(1);
		push_request(FN_FWD, 0, 0, 0, 0);
		push_request(FN_INV, 0, 0, 0, -1);
		wait_idle();

		while (requests_made < TARGET_REQUESTS) begin
			phases_run++;
			no_idle = (phases_run % 4 == 0);
			case (phases_run % 12)
				5: n = DEPTH;
				7: n = 1;
				9: n = 0;
				default: n = $urandom_range(2, 20);
			endcase
			shape = $urandom_range(0, 3);
			a = -longint'($urandom_range(0, 32'h40000000));
			p = 0;
			// Load every entry the queries can reach before they can reach it.
			for (int i = 0; i < n; i++) begin
				case (shape)
					0: begin
						a += $urandom_range(1, 1 << 20);
						p += $urandom_range(0, 8000);
					end
					1: begin
						// Repeated keys: equal neighbors are skipped by the search.
						a += ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 1 << 16);
						p += ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4000);
					end
					default: begin
						a = longint'($signed($urandom()));
						p = $urandom_range(0, 17'h1FFFF);
					end
				endcase
				push_request(FN_LOAD, i[7:0], a, (p > 17'h1FFFF) ? 17'h1FFFF : p, 0);
			end
			wait_idle();
			write_entries(n);
			if (phases_run == 3) begin
				@(negedge clk);
				hold_requests++;
			end
			count = $urandom_range(10, 40);
			for (int j = 0; j < count; j++) begin
				case ($urandom_range(0, 19))
					0: push_request(FN_NONE, 8'($urandom()), $urandom(), $urandom(),
						$urandom());
					1, 2: push_request(FN_LOAD, 8'($urandom_range(0, DEPTH - 1)),
						longint'($signed($urandom())), $urandom_range(0, 17'h1FFFF), $urandom());
					default: begin
						if ($urandom_range(0, 1) == 0)
							push_request(FN_FWD, 8'($urandom()), $urandom(), $urandom(),
								pick_query(1'b0, n));
						else
							push_request(FN_INV, 8'($urandom()), $urandom(), $urandom(),
								pick_query(1'b1, n));
					end
				endcase
			end
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Covered %0d phases with %0d loads and %0d queries; %0d results checked.",
			phases_run, loads_sent, queries_sent, results_seen);
		$display("Table sizes from empty to the full depth, sorted, repeated and unsorted keys.");
		if (mismatches == 0 && owed_results.size() == 0) begin
			$display("table_linear_interpolator_unit_tb OK");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches,
				owed_results.size());
			$display("table_linear_interpolator_unit_tb NOT OK");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tli_pkg.sv
rtl/tli_dpath.sv
rtl/tli_ctrl.sv
rtl/table_linear_interpolator_unit.sv
verif/table_linear_interpolator_unit_tb.sv
